/* rtl/core/rbei_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_pkg
// Shared codes and the control/status bundles between the integrator's
// sequencer and datapath.
// ----------------------------------------------------------------------------
package rbei_pkg;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_FORCE  = 3'd2;
	localparam logic [2:0] CMD_STEP   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_BODY  = 3'd1;
	localparam logic [2:0] ST_STATIC   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BAD_STEP = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_GRAV_X = 2'd0;
	localparam logic [1:0] REG_GRAV_Y = 2'd1;
	localparam logic [1:0] REG_GRAV_Z = 2'd2;

	typedef struct packed {
		logic       load;
		logic       idx_inc;
		logic       k_inc;
		logic       rd_mass;
		logic       rd_vec;
		logic       div_start;
		logic       acc_calc;
		logic       mul_acc;
		logic       upd_vel;
		logic       mul_vel;
		logic       upd_pos;
		logic       add_wr;
		logic       force_wr;
		logic       capture;
		logic       set_valid;
		logic       clr_valid;
		logic       clear_all;
		logic       time_add;
		logic       count_inc;
		logic       slot_from_idx;
		logic       set_status;
		logic [2:0] status;
		logic       publish;
	} rbei_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       id_ok;
		logic       idx_valid;
		logic       idx_last;
		logic       k_last;
		logic       mass_zero;
		logic       dt_bad;
		logic       div_busy;
	} rbei_stat_t;

endpackage
`default_nettype wire

/* rtl/core/rbei_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_dpath
// Body tables, gravity registers, restoring divider, shared multiplier,
// saturating adders and the result/output registers.
// ----------------------------------------------------------------------------
module rbei_dpath #(
	parameter int MAX_BODIES = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbei_pkg::rbei_cmd_t ctl,
	output rbei_pkg::rbei_stat_t     stat,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic [2:0]          cmd,
	input  wire logic [5:0]          body_id,
	input  wire logic [31:0]         mass,
	input  wire logic signed [31:0]  vec_x,
	input  wire logic signed [31:0]  vec_y,
	input  wire logic signed [31:0]  vec_z,
	input  wire logic signed [31:0]  vel_x,
	input  wire logic signed [31:0]  vel_y,
	input  wire logic signed [31:0]  vel_z,
	input  wire logic signed [31:0]  time_step,
	output logic [2:0]               status,
	output logic [5:0]               slot,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic signed [31:0]       pos_z,
	output logic signed [31:0]       speed_x,
	output logic signed [31:0]       speed_y,
	output logic signed [31:0]       speed_z,
	output logic [6:0]               integrated_count,
	output logic [47:0]              elapsed_time,
	output logic [6:0]               live_bodies
);
	import rbei_pkg::*;

	localparam int SW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int VD = MAX_BODIES * 3;
	localparam int AW = $clog2(VD);
	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int QW = DW + 1;
	localparam logic [SW-1:0] LAST_IDX  = SW'(MAX_BODIES - 1);
	localparam logic [CW-1:0] DIV_STEPS = CW'(DW);
	localparam logic [1:0]    LAST_K    = 2'd2;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// latched command
	logic [2:0]         cmd_q;
	logic [5:0]         id_q;
	logic [31:0]        mass_q;
	logic signed [31:0] vec_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] dt_q;

	logic signed [31:0] grav_q [3];
	logic [SW-1:0]      idx_q;
	logic [1:0]         k_q;
	logic [MAX_BODIES-1:0] slot_valid_q;
	logic [6:0]         body_total_q;
	logic [47:0]        time_total_q;

	logic [AW-1:0] addr;
	assign addr = AW'({idx_q, 1'b0}) + AW'(idx_q) + AW'(k_q);

	// tables
	logic [31:0]        mass_mem [MAX_BODIES];
	logic signed [31:0] pos_mem  [VD];
	logic signed [31:0] vel_mem  [VD];
	logic signed [31:0] frc_mem  [VD];
	logic [31:0]        mass_rd_q;
	logic signed [31:0] pos_rd_q, vel_rd_q, frc_rd_q;

	// arithmetic
	logic [DW-1:0]        dvd_q;
	logic [31:0]          rem_q;
	logic [CW-1:0]        dcnt_q;
	logic                 div_busy_q, neg_q;
	logic [32:0]          shifted;
	logic [33:0]          diff;
	logic                 ge;
	logic [31:0]          fmag;
	logic signed [QW-1:0] qs;
	logic signed [31:0]   acc_q, v_q, mul_a;
	logic signed [63:0]   prod_q, prod_sh;
	logic signed [31:0]   vel_new, pos_new, frc_sum;
	logic                 pos_we, vel_we, frc_we;
	logic signed [31:0]   pos_wd, vel_wd, frc_wd;

	// working result and output register
	logic [2:0]         status_w_q, status_q;
	logic [5:0]         slot_w_q, slot_q;
	logic signed [31:0] pos_w_q [3];
	logic signed [31:0] spd_w_q [3];
	logic signed [31:0] pos_o_q [3];
	logic signed [31:0] spd_o_q [3];
	logic [6:0]         count_w_q, count_q;
	logic [47:0]        time_o_q;
	logic [6:0]         live_o_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			id_q     <= body_id;
			mass_q   <= mass;
			vec_q[0] <= vec_x;
			vec_q[1] <= vec_y;
			vec_q[2] <= vec_z;
			vel_q[0] <= vel_x;
			vel_q[1] <= vel_y;
			vel_q[2] <= vel_z;
			dt_q     <= time_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0] <= '0;
			grav_q[1] <= '0;
			grav_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAV_X: grav_q[0] <= cfg_data;
				REG_GRAV_Y: grav_q[1] <= cfg_data;
				REG_GRAV_Z: grav_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			k_q          <= '0;
			slot_valid_q <= '0;
			body_total_q <= '0;
			time_total_q <= '0;
		end else begin
			if (ctl.load) begin
				k_q <= '0;
				if (cmd == CMD_REMOVE || cmd == CMD_FORCE || cmd == CMD_READ) begin
					idx_q <= SW'(body_id);
				end else begin
					idx_q <= '0;
				end
			end else begin
				if (ctl.idx_inc) idx_q <= idx_q + 1'b1;
				if (ctl.k_inc) k_q <= (k_q == LAST_K) ? 2'd0 : k_q + 2'd1;
			end
			if (ctl.clear_all) begin
				slot_valid_q <= '0;
				body_total_q <= '0;
				time_total_q <= '0;
			end else begin
				if (ctl.set_valid) begin
					slot_valid_q[idx_q] <= 1'b1;
					body_total_q        <= body_total_q + 7'd1;
				end
				if (ctl.clr_valid) begin
					slot_valid_q[idx_q] <= 1'b0;
					body_total_q        <= body_total_q - 7'd1;
				end
				if (ctl.time_add) time_total_q <= time_total_q + 48'($unsigned(dt_q));
			end
		end
	end

	// table ports: one write and one registered read each
	assign pos_we = ctl.add_wr | ctl.upd_pos;
	assign vel_we = ctl.add_wr | ctl.upd_vel;
	assign frc_we = ctl.add_wr | ctl.force_wr | ctl.upd_pos;
	assign pos_wd = ctl.add_wr ? vec_q[k_q] : pos_new;
	assign vel_wd = ctl.add_wr ? vel_q[k_q] : vel_new;
	assign frc_wd = ctl.force_wr ? frc_sum : 32'sd0;

	always_ff @(posedge clk) begin
		if (ctl.add_wr) mass_mem[idx_q] <= mass_q;
		if (ctl.rd_mass) mass_rd_q <= mass_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[addr] <= pos_wd;
		if (ctl.rd_vec) pos_rd_q <= pos_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (vel_we) vel_mem[addr] <= vel_wd;
		if (ctl.rd_vec) vel_rd_q <= vel_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (frc_we) frc_mem[addr] <= frc_wd;
		if (ctl.rd_vec) frc_rd_q <= frc_mem[addr];
	end

	// restoring divider on magnitudes, one quotient bit a cycle
	assign fmag    = frc_rd_q[31] ? (~frc_rd_q + 32'd1) : frc_rd_q;
	assign shifted = {rem_q, dvd_q[DW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, mass_rd_q};
	assign ge      = !diff[33];
	assign qs      = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (ctl.div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= DIV_STEPS;
		end else if (div_busy_q) begin
			div_busy_q <= (dcnt_q != CW'(1));
			dcnt_q     <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			dvd_q <= DW'(fmag) << FRAC_BITS;
			rem_q <= '0;
			neg_q <= frc_rd_q[31];
		end else if (div_busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	// shared multiplier, floor shift back to fixed point
	assign mul_a   = ctl.mul_vel ? v_q : acc_q;
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign vel_new = sat32(66'(vel_rd_q) + 66'(prod_sh));
	assign pos_new = sat32(66'(pos_rd_q) + 66'(prod_sh));
	assign frc_sum = sat32(66'(frc_rd_q) + 66'(vec_q[k_q]));

	always_ff @(posedge clk) begin
		if (ctl.acc_calc) acc_q <= sat32(66'(grav_q[k_q]) + 66'(qs));
		if (ctl.mul_acc || ctl.mul_vel) prod_q <= mul_a * dt_q;
		if (ctl.upd_vel) v_q <= vel_new;
	end

	// working result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status_w_q <= ST_OK;
			slot_w_q   <= (cmd == CMD_REMOVE || cmd == CMD_FORCE || cmd == CMD_READ) ?
				body_id : 6'd0;
			pos_w_q[0] <= '0;
			pos_w_q[1] <= '0;
			pos_w_q[2] <= '0;
			spd_w_q[0] <= '0;
			spd_w_q[1] <= '0;
			spd_w_q[2] <= '0;
			count_w_q  <= '0;
		end else begin
			if (ctl.set_status) status_w_q <= ctl.status;
			if (ctl.slot_from_idx) slot_w_q <= 6'(idx_q);
			if (ctl.capture) begin
				pos_w_q[k_q] <= pos_rd_q;
				spd_w_q[k_q] <= vel_rd_q;
			end
			if (ctl.count_inc) count_w_q <= count_w_q + 7'd1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			status_q   <= status_w_q;
			slot_q     <= slot_w_q;
			pos_o_q[0] <= pos_w_q[0];
			pos_o_q[1] <= pos_w_q[1];
			pos_o_q[2] <= pos_w_q[2];
			spd_o_q[0] <= spd_w_q[0];
			spd_o_q[1] <= spd_w_q[1];
			spd_o_q[2] <= spd_w_q[2];
			count_q    <= count_w_q;
			time_o_q   <= time_total_q;
			live_o_q   <= body_total_q;
		end
	end

	assign status           = status_q;
	assign slot             = slot_q;
	assign pos_x            = pos_o_q[0];
	assign pos_y            = pos_o_q[1];
	assign pos_z            = pos_o_q[2];
	assign speed_x          = spd_o_q[0];
	assign speed_y          = spd_o_q[1];
	assign speed_z          = spd_o_q[2];
	assign integrated_count = count_q;
	assign elapsed_time     = time_o_q;
	assign live_bodies      = live_o_q;

	assign stat.cmd       = cmd_q;
	assign stat.id_ok     = (int'(id_q) < MAX_BODIES) && slot_valid_q[idx_q];
	assign stat.idx_valid = slot_valid_q[idx_q];
	assign stat.idx_last  = (idx_q == LAST_IDX);
	assign stat.k_last    = (k_q == LAST_K);
	assign stat.mass_zero = (mass_rd_q == 32'd0);
	assign stat.dt_bad    = dt_q[31] || (dt_q == 32'sd0);
	assign stat.div_busy  = div_busy_q;

	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		7'($countones(slot_valid_q)) == body_total_q)
		else $error("live body count out of step with valid bits");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |-> !div_busy_q)
		else $error("divider restarted while busy");

	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_wr |-> !slot_valid_q[idx_q])
		else $error("add writes into an occupied slot");

endmodule
`default_nettype wire

/* rtl/core/rbei_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_ctrl
// Command sequencer: handshakes, slot scan, per-body and per-axis stepping.
// ----------------------------------------------------------------------------
module rbei_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire rbei_pkg::rbei_stat_t stat,
	output rbei_pkg::rbei_cmd_t       ctl
);
	import rbei_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_ASCAN = 5'd2;
	localparam logic [4:0] S_AWR   = 5'd3;
	localparam logic [4:0] S_FMASS = 5'd4;
	localparam logic [4:0] S_FRD   = 5'd5;
	localparam logic [4:0] S_FWR   = 5'd6;
	localparam logic [4:0] S_RRD   = 5'd7;
	localparam logic [4:0] S_RCAP  = 5'd8;
	localparam logic [4:0] S_CHECK = 5'd9;
	localparam logic [4:0] S_SMASS = 5'd10;
	localparam logic [4:0] S_SRD   = 5'd11;
	localparam logic [4:0] S_DIVGO = 5'd12;
	localparam logic [4:0] S_DIV   = 5'd13;
	localparam logic [4:0] S_ACC   = 5'd14;
	localparam logic [4:0] S_MUL1  = 5'd15;
	localparam logic [4:0] S_VEL   = 5'd16;
	localparam logic [4:0] S_MUL2  = 5'd17;
	localparam logic [4:0] S_POS   = 5'd18;
	localparam logic [4:0] S_NEXT  = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.cmd)
					CMD_ADD: state_d = S_ASCAN;
					CMD_REMOVE, CMD_FORCE, CMD_READ: begin
						if (!stat.id_ok) begin
							ctl.set_status = 1'b1;
							ctl.status     = ST_NO_BODY;
							state_d        = S_DONE;
						end else if (stat.cmd == CMD_REMOVE) begin
							ctl.clr_valid = 1'b1;
							state_d       = S_DONE;
						end else if (stat.cmd == CMD_FORCE) begin
							ctl.rd_mass = 1'b1;
							state_d     = S_FMASS;
						end else begin
							state_d = S_RRD;
						end
					end
					CMD_STEP: begin
						if (stat.dt_bad) begin
							ctl.set_status = 1'b1;
							ctl.status     = ST_BAD_STEP;
							state_d        = S_DONE;
						end else begin
							state_d = S_CHECK;
						end
					end
					CMD_CLEAR: begin
						ctl.clear_all = 1'b1;
						state_d       = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ASCAN: begin
				if (!stat.idx_valid) begin
					state_d = S_AWR;
				end else if (stat.idx_last) begin
					ctl.set_status = 1'b1;
					ctl.status     = ST_FULL;
					state_d        = S_DONE;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_AWR: begin
				ctl.add_wr = 1'b1;
				ctl.k_inc  = 1'b1;
				if (stat.k_last) begin
					ctl.set_valid     = 1'b1;
					ctl.slot_from_idx = 1'b1;
					state_d           = S_DONE;
				end
			end
			S_FMASS: begin
				if (stat.mass_zero) begin
					ctl.set_status = 1'b1;
					ctl.status     = ST_STATIC;
					state_d        = S_DONE;
				end else begin
					state_d = S_FRD;
				end
			end
			S_FRD: begin
				ctl.rd_vec = 1'b1;
				state_d    = S_FWR;
			end
			S_FWR: begin
				ctl.force_wr = 1'b1;
				ctl.k_inc    = 1'b1;
				state_d      = stat.k_last ? S_DONE : S_FRD;
			end
			S_RRD: begin
				ctl.rd_vec = 1'b1;
				state_d    = S_RCAP;
			end
			S_RCAP: begin
				ctl.capture = 1'b1;
				ctl.k_inc   = 1'b1;
				state_d     = stat.k_last ? S_DONE : S_RRD;
			end
			S_CHECK: begin
				if (stat.idx_valid) begin
					ctl.rd_mass = 1'b1;
					state_d     = S_SMASS;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_SMASS: state_d = stat.mass_zero ? S_NEXT : S_SRD;
			S_SRD: begin
				ctl.rd_vec = 1'b1;
				state_d    = S_DIVGO;
			end
			S_DIVGO: begin
				ctl.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (!stat.div_busy) state_d = S_ACC;
			end
			S_ACC: begin
				ctl.acc_calc = 1'b1;
				state_d      = S_MUL1;
			end
			S_MUL1: begin
				ctl.mul_acc = 1'b1;
				state_d     = S_VEL;
			end
			S_VEL: begin
				ctl.upd_vel = 1'b1;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				ctl.mul_vel = 1'b1;
				state_d     = S_POS;
			end
			S_POS: begin
				ctl.upd_pos = 1'b1;
				ctl.k_inc   = 1'b1;
				if (stat.k_last) begin
					ctl.count_inc = 1'b1;
					state_d       = S_NEXT;
				end else begin
					state_d = S_SRD;
				end
			end
			S_NEXT: begin
				if (stat.idx_last) begin
					ctl.time_add = 1'b1;
					state_d      = S_DONE;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("transfer accepted but sequencer stayed idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && !$past(ctl.publish))
		else $error("result register overwritten before transfer");

	a_done_publish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> state_q == S_IDLE && out_valid_q)
		else $error("finished result not published");

endmodule
`default_nettype wire

/* rtl/core/rigid_body_euler_integrator.sv */
`default_nettype none
// An add scans the slots for a free one; a force ends early on a static body; remove,
// force and read end early on a missing body, and a step ends early on a bad time step.
// A step walks every slot: empty and static slots are passed over, and each moving body
// is set by the one-bit-a-cycle divider run once per axis.
// Throughput: one item in work at a time; the next is taken the cycle after the result
// is loaded, even while it waits. Reset (arst_n low) clears table, time, gravity at once.
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator
// Fixed-point point-body table with semi-implicit Euler stepping.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator #(
	parameter int MAX_BODIES = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         cmd,
	input  wire logic [5:0]         body_id,
	input  wire logic [31:0]        mass,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	input  wire logic signed [31:0] time_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [5:0]              slot,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      speed_x,
	output logic signed [31:0]      speed_y,
	output logic signed [31:0]      speed_z,
	output logic [6:0]              integrated_count,
	output logic [47:0]             elapsed_time,
	output logic [6:0]              live_bodies
);
	import rbei_pkg::*;

	rbei_cmd_t  ctl;
	rbei_stat_t stat;

	assign cfg_ready = 1'b1;

	rbei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	rbei_dpath #(
		.MAX_BODIES (MAX_BODIES),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cfg_we           (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.body_id          (body_id),
		.mass             (mass),
		.vec_x            (vec_x),
		.vec_y            (vec_y),
		.vec_z            (vec_z),
		.vel_x            (vel_x),
		.vel_y            (vel_y),
		.vel_z            (vel_z),
		.time_step        (time_step),
		.status           (status),
		.slot             (slot),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.speed_x          (speed_x),
		.speed_y          (speed_y),
		.speed_z          (speed_z),
		.integrated_count (integrated_count),
		.elapsed_time     (elapsed_time),
		.live_bodies      (live_bodies)
	);

endmodule
`default_nettype wire

/* sim/rigid_body_euler_integrator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator_test
// Self-checking bench for the point-body integrator. A directed table, then
// random add/remove/force/step/read/clear traffic over several gravity
// settings. Every response is compared with a behavioural body table.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator_test;
	import rbei_pkg::*;

	typedef struct {
		bit [2:0]  cmd;
		bit [5:0]  id;
		bit [31:0] mass;
		bit [31:0] vec [3];
		bit [31:0] vel [3];
		bit [31:0] dt;
	} body_cmd_t;

	typedef struct {
		bit [2:0]  status;
		bit [5:0]  slot;
		bit [31:0] pos [3];
		bit [31:0] spd [3];
		bit [6:0]  count;
		bit [47:0] elapsed;
		bit [6:0]  live;
	} body_resp_t;

	typedef struct {
		body_cmd_t c;
		bit        typed;
		bit [2:0]  exp_status;
		bit [5:0]  exp_slot;
	} table_row_t;

	localparam int WATCHDOG_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [5:0] body_id = '0;
	logic [31:0] mass = '0;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic signed [31:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [5:0] slot;
	logic signed [31:0] pos_x, pos_y, pos_z, speed_x, speed_y, speed_z;
	logic [6:0] integrated_count;
	logic [47:0] elapsed_time;
	logic [6:0] live_bodies;

	rigid_body_euler_integrator DUT (.*);

	always #1 clk = ~clk;

	// body table held by the bench
	int gravity [3];
	bit body_live [64];
	bit [31:0] body_mass [64];
	int body_pos [64][3];
	int body_vel [64][3];
	int body_force [64][3];
	bit [47:0] sim_clock;
	int body_count;

	body_resp_t pending_resp [$];
	table_row_t dir_rows [$];
	int errors = 0;
	int n_items = 0, n_steps = 0, n_moved = 0, n_full = 0, n_resp = 0;
	bit idle_on = 1'b1;
	int quiet_cycles = 0;

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic body_resp_t predict_response(body_cmd_t c);
		body_resp_t r;
		int freeslot;
		longint dt, m, f;
		int acc, v;
		r = '{default: '0};
		case (c.cmd)
			CMD_ADD: begin
				freeslot = -1;
				for (int i = 63; i >= 0; i--)
					if (!body_live[i]) freeslot = i;
				if (freeslot < 0) begin
					r.status = ST_FULL;
				end else begin
					body_live[freeslot] = 1'b1;
					body_mass[freeslot] = c.mass;
					for (int k = 0; k < 3; k++) begin
						body_pos[freeslot][k] = c.vec[k];
						body_vel[freeslot][k] = c.vel[k];
						body_force[freeslot][k] = 0;
					end
					body_count++;
					r.slot = 6'(freeslot);
				end
			end
			CMD_REMOVE, CMD_FORCE, CMD_READ: begin
				r.slot = c.id;
				if (!body_live[c.id]) begin
					r.status = ST_NO_BODY;
				end else if (c.cmd == CMD_REMOVE) begin
					body_live[c.id] = 1'b0;
					body_count--;
				end else if (c.cmd == CMD_FORCE) begin
					if (body_mass[c.id] == 0) r.status = ST_STATIC;
					else
						for (int k = 0; k < 3; k++)
							body_force[c.id][k] = sat32(longint'(body_force[c.id][k])
								+ longint'($signed(c.vec[k])));
				end else begin
					for (int k = 0; k < 3; k++) begin
						r.pos[k] = body_pos[c.id][k];
						r.spd[k] = body_vel[c.id][k];
					end
				end
			end
			CMD_STEP: begin
				dt = longint'($signed(c.dt));
				if (dt <= 0) begin
					r.status = ST_BAD_STEP;
				end else begin
					for (int i = 0; i < 64; i++) begin
						if (!body_live[i] || body_mass[i] == 0) continue;
						m = longint'(body_mass[i]);
						for (int k = 0; k < 3; k++) begin
							f = longint'(body_force[i][k]) * 65536;
							acc = sat32(longint'(gravity[k]) + f / m);
							v = sat32(longint'(body_vel[i][k]) + qmul(acc, dt));
							body_vel[i][k] = v;
							body_pos[i][k] = sat32(longint'(body_pos[i][k]) + qmul(v, dt));
							body_force[i][k] = 0;
						end
						r.count++;
					end
					sim_clock = sim_clock + dt[47:0];
				end
			end
			CMD_CLEAR: begin
				foreach (body_live[i]) body_live[i] = 1'b0;
				body_count = 0;
				sim_clock = '0;
			end
			default: ;
		endcase
		r.elapsed = sim_clock;
		r.live = body_count[6:0];
		return r;
	endfunction

	task automatic add_row(body_cmd_t c, bit typed, bit [2:0] es, bit [5:0] esl);
		table_row_t row;
		row.c = c;
		row.typed = typed;
		row.exp_status = es;
		row.exp_slot = esl;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic send_cmd(body_cmd_t c, bit typed = 0, bit [2:0] es = 0, bit [5:0] esl = 0);
		int gap;
		body_resp_t r;
		gap = (idle_on && $urandom_range(99) < 28) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c.cmd;
		body_id <= c.id;
		mass <= c.mass;
		vec_x <= c.vec[0];
		vec_y <= c.vec[1];
		vec_z <= c.vec[2];
		vel_x <= c.vel[0];
		vel_y <= c.vel[1];
		vel_z <= c.vel[2];
		time_step <= c.dt;
		do @(posedge clk); while (!in_ready);
		r = predict_response(c);
		if (typed) begin
			r.status = es;
			r.slot = esl;
		end
		pending_resp.insert(pending_resp.size(), r);
		n_items++;
		if (c.cmd == CMD_STEP && r.status == ST_OK) begin
			n_steps++;
			n_moved += r.count;
		end
		if (r.status == ST_FULL) n_full++;
	endtask

	// waits out every outstanding response; the block is then idle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_gravity(bit [1:0] idx, bit [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		gravity[idx] = value;
	endtask

	function automatic body_cmd_t make_cmd(bit [2:0] op, bit [5:0] id, bit [31:0] m,
		bit [31:0] v, bit [31:0] s, bit [31:0] dt);
		body_cmd_t c;
		c.cmd = op;
		c.id = id;
		c.mass = m;
		c.dt = dt;
		for (int k = 0; k < 3; k++) begin
			c.vec[k] = v;
			c.vel[k] = s;
		end
		return c;
	endfunction

	function automatic bit [31:0] rand_q();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h7ffff) - 32'h40000;
			2: return $urandom_range(0, 16'hffff);
			default: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
		endcase
	endfunction

	function automatic bit [5:0] pick_id();
		int start;
		start = $urandom_range(63);
		if (body_count > 0 && $urandom_range(99) < 80)
			for (int i = 0; i < 64; i++)
				if (body_live[(start + i) % 64]) return 6'((start + i) % 64);
		return 6'(start);
	endfunction

	function automatic body_cmd_t random_cmd();
		body_cmd_t c;
		int p;
		p = $urandom_range(99);
		if (body_count > 24 && p < 25) p = 30;
		c.cmd = p < 25 ? CMD_ADD : p < 38 ? CMD_REMOVE : p < 62 ? CMD_FORCE :
			p < 72 ? CMD_STEP : p < 94 ? CMD_READ : p < 96 ? CMD_CLEAR :
			3'($urandom_range(6, 7));
		c.id = pick_id();
		case ($urandom_range(3))
			0: c.mass = 0;
			1: c.mass = $urandom();
			default: c.mass = $urandom_range(32'h1000, 32'h80000);
		endcase
		for (int k = 0; k < 3; k++) begin
			c.vec[k] = rand_q();
			c.vel[k] = rand_q();
		end
		p = $urandom_range(99);
		c.dt = p < 8 ? 32'h0 - $urandom_range(0, 3) : p < 12 ? $urandom() :
			p < 15 ? {1'b0, 31'($urandom())} : $urandom_range(1, 32'h20000);
		return c;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// response side
	always @(posedge clk) begin
		body_resp_t w;
		out_ready <= !(idle_on && $urandom_range(99) < 28);
		if (out_valid && out_ready) begin
			n_resp++;
			if (pending_resp.size() == 0) begin
				errors++;
				$display("%0t: response with none expected (status %0d)", $realtime, status);
			end else begin
				w = pending_resp.pop_front();
				check_field("status", w.status, status);
				check_field("slot", w.slot, slot);
				check_field("pos_x", w.pos[0], $unsigned(pos_x));
				check_field("pos_y", w.pos[1], $unsigned(pos_y));
				check_field("pos_z", w.pos[2], $unsigned(pos_z));
				check_field("speed_x", w.spd[0], $unsigned(speed_x));
				check_field("speed_y", w.spd[1], $unsigned(speed_y));
				check_field("speed_z", w.spd[2], $unsigned(speed_z));
				check_field("integrated_count", w.count, integrated_count);
				check_field("elapsed_time", w.elapsed, elapsed_time);
				check_field("live_bodies", w.live, live_bodies);
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $realtime);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		body_cmd_t c;
		bit [31:0] gsets [5][3];
		gravity = '{0, 0, 0};
		sim_clock = '0;
		body_count = 0;
		foreach (body_live[i]) body_live[i] = 1'b0;

		// state straight after reset, error codes, extremes
		add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 0), 1, ST_NO_BODY, 0);
		add_row(make_cmd(CMD_REMOVE, 63, 0, 0, 0, 0), 1, ST_NO_BODY, 63);
		add_row(make_cmd(CMD_STEP, 0, 0, 0, 0, 0), 1, ST_BAD_STEP, 0);
		add_row(make_cmd(CMD_STEP, 0, 0, 0, 0, 32'h80000000), 1, ST_BAD_STEP, 0);
		add_row(make_cmd(CMD_ADD, 7, 0, 32'h7fffffff, 32'h80000000, 0), 1, ST_OK, 0);
		add_row(make_cmd(CMD_ADD, 0, 1, 32'h80000000, 32'h7fffffff, 0), 1, ST_OK, 1);
		add_row(make_cmd(CMD_ADD, 0, 32'hffffffff, 32'h10000, 32'hffff0000, 0),
			1, ST_OK, 2);
		add_row(make_cmd(CMD_FORCE, 0, 0, 32'h10000, 0, 0), 1, ST_STATIC, 0);
		add_row(make_cmd(CMD_FORCE, 1, 0, 32'h7fffffff, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_FORCE, 1, 0, 32'h7fffffff, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_FORCE, 2, 0, 32'h80000000, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_FORCE, 5, 0, 1, 0, 0), 1, ST_NO_BODY, 5);
		add_row(make_cmd(CMD_STEP, 0, 0, 0, 0, 1), 0, 0, 0);
		add_row(make_cmd(CMD_STEP, 0, 0, 0, 0, 32'h7fffffff), 0, 0, 0);
		add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_READ, 1, 0, 0, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_READ, 2, 0, 0, 0, 0), 0, 0, 0);
		add_row(make_cmd(3'd6, 9, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff), 0, 0, 0);
		add_row(make_cmd(3'd7, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(make_cmd(CMD_REMOVE, 1, 0, 0, 0, 0), 1, ST_OK, 1);
		add_row(make_cmd(CMD_ADD, 0, 32'h10000, 0, 0, 0), 1, ST_OK, 1);
		add_row(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0), 1, ST_OK, 0);
		add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 0), 1, ST_NO_BODY, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed,
			dir_rows[i].exp_status, dir_rows[i].exp_slot);

		// fill every slot, overflow once, step a full table, then empty it
		for (int i = 0; i < 65; i++) begin
			c = random_cmd();
			c.cmd = CMD_ADD;
			c.mass = $urandom_range(1, 32'h40000);
			send_cmd(c);
		end
		for (int i = 0; i < 64; i += 7) begin
			c = random_cmd();
			c.cmd = CMD_FORCE;
			c.id = 6'(i);
			send_cmd(c);
		end
		send_cmd(make_cmd(CMD_STEP, 0, 0, 0, 0, 32'h8000));
		send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
		drain();

		gsets[0] = '{32'h7fffffff, 32'h80000000, 32'h0};
		gsets[1] = '{32'h80000000, 32'h7fffffff, 32'hffffffff};
		gsets[2] = '{32'hfff63000, 32'h00001000, 32'h00000001};
		gsets[3] = '{$urandom(), $urandom(), $urandom()};
		gsets[4] = '{32'h0, 32'h0, 32'h0};
		for (int ph = 0; ph < 5; ph++) begin
			write_gravity(REG_GRAV_X, gsets[ph][0]);
			write_gravity(REG_GRAV_Y, gsets[ph][1]);
			write_gravity(REG_GRAV_Z, gsets[ph][2]);
			cfg_valid <= 1'b0;
			// one phase runs back to back on both sides
			idle_on = (ph != 2);
			for (int n = 0; n < 230; n++) send_cmd(random_cmd());
			drain();
		end
		idle_on = 1'b1;

		while (pending_resp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("%0d commands, %0d responses; %0d steps moved %0d bodies, %0d adds refused",
			n_items, n_resp, n_steps, n_moved, n_full);
		$display("gravity swept through extremes in %0d settings", 5);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/core/rbei_pkg.sv
rtl/core/rbei_dpath.sv
rtl/core/rbei_ctrl.sv
rtl/core/rigid_body_euler_integrator.sv
sim/rigid_body_euler_integrator_test.sv
